// ===== hdl/fxaa_pkg.sv =====
package fxaa_pkg;

  localparam int MaxLine = 1024;
  localparam int ColW    = $clog2(MaxLine);
  localparam int WidthW  = 11;
  localparam int HeightW = 13;
  localparam int FloorW  = 10;
  localparam int CapW    = 9;
  localparam int LumaW   = 18;
  localparam int SdW     = 24;
  localparam int RemW    = 27;
  localparam int CntW    = 24;
  localparam int RowW    = 14;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FLOOR  = 2'd2,
    CFG_CAP    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LUMA,
    ST_EDGE,
    ST_DIV,
    ST_MIX,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic shift;
    logic luma;
    logic edge_det;
    logic div_step;
    logic mix;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic ignore;
    logic emit;
    logic pass;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic [LumaW-1:0] luma_of(input logic [31:0] px);
    return LumaW'(px[31:24]) * LumaW'(306) + LumaW'(px[23:16]) * LumaW'(601)
         + LumaW'(px[15:8]) * LumaW'(117);
  endfunction

  function automatic logic signed [SdW-1:0] sd2(input logic [LumaW-1:0] a,
                                                input logic [LumaW-1:0] m,
                                                input logic [LumaW-1:0] c);
    return $signed(SdW'(a)) + $signed(SdW'(c)) - ($signed(SdW'(m)) <<< 1);
  endfunction

  function automatic logic [SdW-1:0] absd(input logic signed [SdW-1:0] v);
    return (v < 0) ? SdW'(-v) : SdW'(v);
  endfunction

  function automatic logic [7:0] mix_chan(input logic [7:0] c, input logic [7:0] n,
                                          input logic [8:0] b);
    logic [16:0] s;
    s = 17'(c) * 17'(9'd256 - b) + 17'(n) * 17'(b);
    return s[15:8];
  endfunction

endpackage

// ===== hdl/fxaa_pixel_stream_filter_top.sv =====
// Streaming edge-smoothing filter for raster RGBA video. Each accepted request
// is one pixel (or a drain marker); the result for a pixel appears one line plus
// one pixel later, and after the last pixel of a frame the source sends
// width+1 drain requests to flush it. Requests are handled one at a time by a
// sequencer around the two line stores: an item with no result passes only the
// read state, a pass-through pixel also the luma, edge and output states, a
// blended pixel also the blend-factor divider and mix; a result still waiting in
// the output register holds it in output. A drain at the very start of a frame is
// dropped in idle. Writing width or height restarts the frame position.
module fxaa_pixel_stream_filter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pix_red, pix_green, pix_blue, pix_alpha
  input  logic [0:0]  in_tuser,   // drain
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic [0:0]  out_tuser,  // was_blended
  output logic        out_tlast
);
  import fxaa_pkg::*;

  cmd_t    cmd;
  status_t sts;

  fxaa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fxaa_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== hdl/fxaa_ctrl.sv =====
module fxaa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  fxaa_pkg::status_t sts,
  output fxaa_pkg::cmd_t   cmd
);
  import fxaa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && !sts.ignore) begin
          cmd.take  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.shift = 1'b1;
        state_nxt = sts.emit ? ST_LUMA : ST_IDLE;
      end
      ST_LUMA: begin
        cmd.luma  = 1'b1;
        state_nxt = ST_EDGE;
      end
      ST_EDGE: begin
        cmd.edge_det = 1'b1;
        state_nxt    = sts.pass ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/fxaa_datapath.sv =====
module fxaa_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data,
  input  logic [31:0]       in_tdata,
  input  logic [0:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic [0:0]        out_tuser,
  output logic              out_tlast,
  input  fxaa_pkg::cmd_t    cmd,
  output fxaa_pkg::status_t sts
);
  import fxaa_pkg::*;

  logic [WidthW-1:0]  width_r;
  logic [HeightW-1:0] height_r;
  logic [FloorW-1:0]  floor_r;
  logic [CapW-1:0]    cap_r;
  logic [WidthW-1:0]  eff_w;
  logic [HeightW-1:0] eff_h;
  logic [CntW-1:0]    total_r;

  logic [ColW-1:0]    col_r, x_r;
  logic [RowW-1:0]    row_r;
  logic [CntW-1:0]    ocnt_r;
  logic [ColW-1:0]    ox_r;
  logic [HeightW-1:0] oy_r;
  logic               early_r;
  logic [31:0]        cur_r;

  logic [31:0] above_mem [MaxLine];
  logic [31:0] middle_mem [MaxLine];
  logic [31:0] top_q, mid_q;
  logic [31:0] wreg_r [6];
  logic [31:0] lc_r [3];
  logic [31:0] cc_r [3];
  logic [31:0] rc_r [3];

  logic [31:0] win [3][3];
  logic [LumaW-1:0] l_r [3][3];
  logic [31:0] ctr_r, pn_r, ps_r, pw_r, pe_r, nb_r;
  logic        fend_r, pass_r;

  logic [LumaW-1:0] lmin, lmax, range_c, range_r;
  logic [SdW-1:0]   eh, ev, num;
  logic             horiz;
  logic [31:0]      nb_c;
  logic             pass_c;

  logic [RemW-1:0]  rem_r, trial;
  logic [8:0]       q_r, b_c, cap_eff;
  logic [3:0]       idx_r;
  logic [31:0]      mix_r;

  logic [31:0] out_data_r;
  logic        out_valid_r, out_blend_r, out_last_r;

  assign eff_w = (width_r == '0) ? WidthW'(1) :
                 (width_r > WidthW'(MaxLine)) ? WidthW'(MaxLine) : width_r;
  assign eff_h = (height_r == '0) ? HeightW'(1) : height_r;

  always_ff @(posedge clk) begin
    total_r <= CntW'(eff_w) * CntW'(eff_h);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WidthW'(256);
      height_r <= HeightW'(224);
      floor_r  <= FloorW'(32);
      cap_r    <= CapW'(192);
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  width_r  <= cfg_data[WidthW-1:0];
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_FLOOR:  floor_r  <= cfg_data[FloorW-1:0];
        CFG_CAP:    cap_r    <= cfg_data[CapW-1:0];
        default: ;
      endcase
    end
  end

  assign sts.ignore   = in_tuser[0] && (col_r == '0) && (row_r == '0);
  assign sts.emit     = !early_r && (ocnt_r < total_r);
  assign sts.div_done = (idx_r == '0);
  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.pass     = pass_c;

  // position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ocnt_r <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
    end else if (cfg_wr_en && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT)) begin
      col_r  <= '0;
      row_r  <= '0;
      ocnt_r <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
    end else if (cmd.shift) begin
      if (WidthW'(col_r) + WidthW'(1) >= eff_w) begin
        col_r <= '0;
        row_r <= row_r + RowW'(1);
      end else begin
        col_r <= col_r + ColW'(1);
      end
    end else if (cmd.luma) begin
      if (ocnt_r + CntW'(1) == total_r) begin
        col_r  <= '0;
        row_r  <= '0;
        ocnt_r <= '0;
        ox_r   <= '0;
        oy_r   <= '0;
      end else begin
        ocnt_r <= ocnt_r + CntW'(1);
        if (WidthW'(ox_r) == eff_w - WidthW'(1)) begin
          ox_r <= '0;
          oy_r <= oy_r + HeightW'(1);
        end else begin
          ox_r <= ox_r + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x_r     <= col_r;
      early_r <= (row_r == '0) || (row_r == RowW'(1) && col_r == '0);
      cur_r   <= (!in_tuser[0] && row_r < RowW'(eff_h)) ?
                 {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]} : '0;
      top_q   <= above_mem[col_r];
      mid_q   <= middle_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      above_mem[x_r]  <= mid_q;
      middle_mem[x_r] <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) wreg_r[i] <= '0;
    end else if (cmd.shift) begin
      wreg_r[0] <= top_q;
      wreg_r[1] <= mid_q;
      wreg_r[2] <= cur_r;
      for (int i = 0; i < 3; i++) wreg_r[3+i] <= wreg_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int i = 0; i < 3; i++) begin
        cc_r[i] <= wreg_r[i];
        lc_r[i] <= wreg_r[3+i];
      end
      rc_r[0] <= top_q;
      rc_r[1] <= mid_q;
      rc_r[2] <= cur_r;
    end
  end

  // border clamp
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      int rr;
      rr = r;
      if (r == 0 && oy_r == '0) rr = 1;
      if (r == 2 && oy_r == eff_h - HeightW'(1)) rr = 1;
      win[r][0] = (ox_r == '0) ? cc_r[rr] : lc_r[rr];
      win[r][1] = cc_r[rr];
      win[r][2] = (WidthW'(ox_r) == eff_w - WidthW'(1)) ? cc_r[rr] : rc_r[rr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.luma) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) l_r[r][c] <= luma_of(win[r][c]);
      end
      ctr_r  <= win[1][1];
      pn_r   <= win[0][1];
      ps_r   <= win[2][1];
      pw_r   <= win[1][0];
      pe_r   <= win[1][2];
      fend_r <= (ocnt_r + CntW'(1) == total_r);
    end
  end

  always_comb begin
    lmin = l_r[1][1];
    lmax = l_r[1][1];
    if (l_r[0][1] < lmin) lmin = l_r[0][1];
    if (l_r[0][1] > lmax) lmax = l_r[0][1];
    if (l_r[2][1] < lmin) lmin = l_r[2][1];
    if (l_r[2][1] > lmax) lmax = l_r[2][1];
    if (l_r[1][2] < lmin) lmin = l_r[1][2];
    if (l_r[1][2] > lmax) lmax = l_r[1][2];
    if (l_r[1][0] < lmin) lmin = l_r[1][0];
    if (l_r[1][0] > lmax) lmax = l_r[1][0];
    range_c = lmax - lmin;
    eh = absd(sd2(l_r[0][0], l_r[1][0], l_r[2][0]))
       + (absd(sd2(l_r[0][1], l_r[1][1], l_r[2][1])) << 1)
       + absd(sd2(l_r[0][2], l_r[1][2], l_r[2][2]));
    ev = absd(sd2(l_r[0][0], l_r[0][1], l_r[0][2]))
       + (absd(sd2(l_r[1][0], l_r[1][1], l_r[1][2])) << 1)
       + absd(sd2(l_r[2][0], l_r[2][1], l_r[2][2]));
    horiz = (eh >= ev);
    if (horiz) begin
      num  = absd(sd2(l_r[0][1], l_r[1][1], l_r[2][1]));
      nb_c = (absd($signed(SdW'(l_r[0][1])) - $signed(SdW'(l_r[1][1]))) >
              absd($signed(SdW'(l_r[2][1])) - $signed(SdW'(l_r[1][1])))) ? pn_r : ps_r;
    end else begin
      num  = absd(sd2(l_r[1][0], l_r[1][1], l_r[1][2]));
      nb_c = (absd($signed(SdW'(l_r[1][0])) - $signed(SdW'(l_r[1][1]))) >
              absd($signed(SdW'(l_r[1][2])) - $signed(SdW'(l_r[1][1])))) ? pw_r : pe_r;
    end
    pass_c = (range_c < LumaW'(floor_r)) || ({range_c, 3'b000} < (LumaW + 3)'(lmax));
  end

  // restoring divide, one quotient bit per cycle, quotient below 512
  assign trial = RemW'(range_r) << idx_r;

  always_ff @(posedge clk) begin
    if (cmd.edge_det) begin
      pass_r  <= pass_c;
      range_r <= range_c;
      nb_r    <= nb_c;
      rem_r   <= RemW'(num) << 7;
      q_r     <= '0;
      idx_r   <= 4'd8;
    end else if (cmd.div_step) begin
      if (rem_r >= trial) begin
        rem_r     <= rem_r - trial;
        q_r[idx_r] <= 1'b1;
      end
      if (idx_r != '0) idx_r <= idx_r - 4'd1;
    end
  end

  assign cap_eff = (cap_r > 9'd256) ? 9'd256 : cap_r;

  always_comb begin
    b_c = (q_r > 9'd256) ? 9'd256 : q_r;
    if (b_c > cap_eff) b_c = cap_eff;
    if (range_r == '0) b_c = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      mix_r <= {mix_chan(ctr_r[31:24], nb_r[31:24], b_c),
                mix_chan(ctr_r[23:16], nb_r[23:16], b_c),
                mix_chan(ctr_r[15:8], nb_r[15:8], b_c),
                8'hFF};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r  <= pass_r ? ctr_r : mix_r;
      out_blend_r <= !pass_r;
      out_last_r  <= fend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r[7:0], out_data_r[15:8], out_data_r[23:16],
                       out_data_r[31:24]};
  assign out_tuser  = out_blend_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== tb/fxaa_pixel_stream_filter_top_tb.sv =====
`timescale 1ns / 1ps

module fxaa_pixel_stream_filter_top_tb;
  import fxaa_pkg::*;

  localparam int LineMax = 1024;
  localparam int Limit   = 1000000;
  localparam int Settle  = 40;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       blended;
    logic       fend;
  } pixel_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = CFG_WIDTH;
  logic [12:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  fxaa_pixel_stream_filter_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  // predictor state; pixels held as {r, g, b, a}
  logic [31:0] line_up [LineMax];
  logic [31:0] line_mid[LineMax];
  logic [31:0] col_new[3];
  logic [31:0] col_old[3];
  int unsigned pos_col, pos_row, out_cnt;
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [9:0]  floor_reg;
  logic [8:0]  cap_reg;

  pixel_out_t  filtered_q[$];
  logic [32:0] request_q[$];   // {drain, tdata}
  logic [32:0] cur_req;
  int          errors = 0;
  int          n_pixels = 0, n_results = 0, n_blended = 0, n_frames = 0;
  int          cycle = 0;
  int          in_gap = 0, out_gap = 0;
  logic        calm;
  logic        hold_arm = 1'b0, hold_done = 1'b0;
  int          hold_cnt = 0;
  wire         hold_on = hold_arm && !hold_done;

  assign calm = cycle[11];

  function automatic longint luma(input logic [31:0] px);
    return 306 * longint'(px[31:24]) + 601 * longint'(px[23:16]) + 117 * longint'(px[15:8]);
  endfunction

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [7:0] blend_chan(input logic [7:0] c, input logic [7:0] n,
                                            input int unsigned b);
    int unsigned s;
    s = int'(c) * (256 - b) + int'(n) * b;
    return s[15:8];
  endfunction

  task automatic filter_pixel(input logic [32:0] req);
    int unsigned w, h, total, p, x, ox, oy, rr, b, capv;
    logic [31:0] cur, top, mid, ctr, nb;
    logic [31:0] rc[3], cc[3], lc[3];
    logic [31:0] win[3][3];
    longint lu[3][3];
    longint lmin, lmax, range, eh, ev, num, q;
    logic drn;
    pixel_out_t res;
    drn = req[32];
    w = (width_reg == 0) ? 1 : (width_reg > LineMax ? LineMax : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    total = w * h;
    if (drn && pos_col == 0 && pos_row == 0) return;
    p = pos_row * w + pos_col;
    cur = '0;
    if (!drn && pos_row < h) cur = {req[7:0], req[15:8], req[23:16], req[31:24]};
    x = pos_col >= LineMax ? LineMax - 1 : pos_col;
    top = line_up[x];
    mid = line_mid[x];
    line_up[x] = mid;
    line_mid[x] = cur;
    rc[0] = top; rc[1] = mid; rc[2] = cur;
    for (int r = 0; r < 3; r++) begin
      cc[r] = col_new[r];
      lc[r] = col_old[r];
      col_old[r] = cc[r];
      col_new[r] = rc[r];
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (p < w + 1 || out_cnt >= total) return;
    ox = out_cnt % w;
    oy = out_cnt / w;
    for (int r = 0; r < 3; r++) begin
      rr = r;
      if (r == 0 && oy == 0) rr = 1;
      if (r == 2 && oy == h - 1) rr = 1;
      win[r][0] = (ox == 0) ? cc[rr] : lc[rr];
      win[r][1] = cc[rr];
      win[r][2] = (ox == w - 1) ? cc[rr] : rc[rr];
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) lu[r][c] = luma(win[r][c]);
    ctr = win[1][1];
    lmin = lu[1][1];
    lmax = lu[1][1];
    foreach (lu[r, c]) begin
      if ((r == 1) != (c == 1)) begin
        if (lu[r][c] < lmin) lmin = lu[r][c];
        if (lu[r][c] > lmax) lmax = lu[r][c];
      end
    end
    range = lmax - lmin;
    out_cnt++;
    res.fend = (out_cnt == total);
    if (res.fend) begin
      pos_col = 0;
      pos_row = 0;
      out_cnt = 0;
    end
    if (range < longint'(floor_reg) || 8 * range < lmax) begin
      {res.red, res.green, res.blue, res.alpha} = ctr;
      res.blended = 1'b0;
    end else begin
      eh = mag(lu[0][0] + lu[2][0] - 2 * lu[1][0]) + 2 * mag(lu[0][1] + lu[2][1] - 2 * lu[1][1])
         + mag(lu[0][2] + lu[2][2] - 2 * lu[1][2]);
      ev = mag(lu[0][0] + lu[0][2] - 2 * lu[0][1]) + 2 * mag(lu[1][0] + lu[1][2] - 2 * lu[1][1])
         + mag(lu[2][0] + lu[2][2] - 2 * lu[2][1]);
      if (eh >= ev) begin
        num = mag(lu[0][1] + lu[2][1] - 2 * lu[1][1]);
        nb = (mag(lu[0][1] - lu[1][1]) > mag(lu[2][1] - lu[1][1])) ? win[0][1] : win[2][1];
      end else begin
        num = mag(lu[1][0] + lu[1][2] - 2 * lu[1][1]);
        nb = (mag(lu[1][0] - lu[1][1]) > mag(lu[1][2] - lu[1][1])) ? win[1][0] : win[1][2];
      end
      b = 0;
      if (range > 0) begin
        q = (128 * num) / range;
        b = q > 256 ? 256 : int'(q);
      end
      capv = cap_reg > 256 ? 256 : cap_reg;
      if (b > capv) b = capv;
      res.red = blend_chan(ctr[31:24], nb[31:24], b);
      res.green = blend_chan(ctr[23:16], nb[23:16], b);
      res.blue = blend_chan(ctr[15:8], nb[15:8], b);
      res.alpha = 8'hFF;
      res.blended = 1'b1;
    end
    filtered_q.push_back(res);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        filter_pixel(cur_req);
        if (!cur_req[32]) n_pixels++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (request_q.size() > 0) begin
          cur_req = request_q.pop_front();
          in_tdata <= cur_req[31:0];
          in_tuser <= cur_req[32];
          in_tvalid <= 1'b1;
          in_gap = calm ? 0 : $urandom_range(0, 3);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_on) begin
      hold_cnt++;
      if (hold_cnt >= 400) hold_done <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    pixel_out_t exp_px;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (filtered_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: exp none act data=%h user=%b last=%b",
                   $time, out_tdata, out_tuser, out_tlast);
        end else begin
          exp_px = filtered_q.pop_front();
          if (exp_px.blended) n_blended++;
          if (exp_px.fend) n_frames++;
          if (out_tdata[7:0] !== exp_px.red) begin
            errors++;
            $display("%0t red mismatch: exp %h act %h", $time, exp_px.red, out_tdata[7:0]);
          end
          if (out_tdata[15:8] !== exp_px.green) begin
            errors++;
            $display("%0t green mismatch: exp %h act %h", $time, exp_px.green,
                     out_tdata[15:8]);
          end
          if (out_tdata[23:16] !== exp_px.blue) begin
            errors++;
            $display("%0t blue mismatch: exp %h act %h", $time, exp_px.blue,
                     out_tdata[23:16]);
          end
          if (out_tdata[31:24] !== exp_px.alpha) begin
            errors++;
            $display("%0t alpha mismatch: exp %h act %h", $time, exp_px.alpha,
                     out_tdata[31:24]);
          end
          if (out_tuser[0] !== exp_px.blended) begin
            errors++;
            $display("%0t blended mismatch: exp %b act %b", $time, exp_px.blended,
                     out_tuser[0]);
          end
          if (out_tlast !== exp_px.fend) begin
            errors++;
            $display("%0t frame end mismatch: exp %b act %b", $time, exp_px.fend, out_tlast);
          end
        end
        out_gap = calm ? 0 : $urandom_range(0, 3);
      end
      if (hold_on) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= Limit) begin
      $display("timeout after %0d cycles", cycle);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    while (request_q.size() > 0 || in_tvalid || filtered_q.size() > 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [12:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_WIDTH: begin
        width_reg = val[10:0];
        pos_col = 0; pos_row = 0; out_cnt = 0;
      end
      CFG_HEIGHT: begin
        height_reg = val;
        pos_col = 0; pos_row = 0; out_cnt = 0;
      end
      CFG_FLOOR: floor_reg = val[9:0];
      default: cap_reg = val[8:0];
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_frame(input int w, input int h, input int fl, input int cp);
    wait_idle();
    cfg_write(CFG_WIDTH, 13'(w));
    cfg_write(CFG_HEIGHT, 13'(h));
    cfg_write(CFG_FLOOR, 13'(fl));
    cfg_write(CFG_CAP, 13'(cp));
  endtask

  function automatic logic [31:0] rand_pixel();
    logic [31:0] px;
    case ($urandom_range(0, 3))
      0: px = $urandom;
      1: for (int i = 0; i < 4; i++) px[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: begin
        px[7:0] = 8'd128 + 8'($urandom_range(0, 15));
        px[15:8] = 8'd128 + 8'($urandom_range(0, 15));
        px[23:16] = 8'd128 + 8'($urandom_range(0, 15));
        px[31:24] = 8'($urandom);
      end
      default: px = $urandom_range(0, 1) ? 32'h0 : {8'($urandom), 24'hFFFFFF};
    endcase
    return px;
  endfunction

  // a full frame plus its flush; oddities only in the random style
  task automatic push_frame(input int w, input int h, input bit odd);
    int weff;
    weff = (w == 0) ? 1 : (w > LineMax ? LineMax : w);
    if (odd && $urandom_range(0, 3) == 0) request_q.push_back({1'b1, 32'($urandom)});
    for (int i = 0; i < weff * ((h == 0) ? 1 : h); i++) begin
      if (odd && $urandom_range(0, 19) == 0) request_q.push_back({1'b1, 32'($urandom)});
      else request_q.push_back({1'b0, rand_pixel()});
    end
    for (int i = 0; i <= weff; i++) begin
      if (odd && i == 0 && $urandom_range(0, 3) == 0)
        request_q.push_back({1'b0, rand_pixel()});
      else request_q.push_back({1'b1, 32'($urandom)});
    end
  endtask

  initial begin
    int w, h, fl, cp;
    foreach (line_up[i]) begin
      line_up[i] = '0;
      line_mid[i] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      col_new[r] = '0;
      col_old[r] = '0;
    end
    pos_col = 0; pos_row = 0; out_cnt = 0;
    width_reg = 11'd256; height_reg = 13'd224; floor_reg = 10'd32; cap_reg = 9'd192;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // 3x3 with extremes, idle drain at frame start, flat dark window
    set_frame(3, 3, 0, 256);
    request_q.push_back({1'b1, 32'hFFFFFFFF});
    request_q.push_back({1'b0, 32'h00000000});
    request_q.push_back({1'b0, 32'h00000000});
    request_q.push_back({1'b0, 32'hFFFFFFFF});
    request_q.push_back({1'b0, 32'h00000000});
    request_q.push_back({1'b0, 32'h00FFFFFF});
    request_q.push_back({1'b0, 32'hFF000000});
    request_q.push_back({1'b0, 32'hFF00FF00});
    request_q.push_back({1'b0, 32'h00FF00FF});
    request_q.push_back({1'b0, 32'h80808080});
    repeat (4) request_q.push_back({1'b1, 32'h0});
    // 2x2 with early drain and a surplus pixel during the flush
    set_frame(2, 2, 1023, 0);
    request_q.push_back({1'b0, 32'h11FFFFFF});
    request_q.push_back({1'b1, 32'h0});
    request_q.push_back({1'b0, 32'h22000000});
    request_q.push_back({1'b0, 32'h33FF00FF});
    request_q.push_back({1'b0, 32'h44FFFFFF});
    request_q.push_back({1'b1, 32'h0});
    request_q.push_back({1'b1, 32'h0});

    // extreme geometries
    set_frame(0, 0, 0, 511);
    push_frame(0, 0, 0);
    set_frame(2047, 1, 16, 128);
    push_frame(1024, 1, 0);
    set_frame(1, 4096, 0, 256);
    repeat (30) request_q.push_back({1'b0, rand_pixel()});

    // random frames until about 750 requests
    for (int sent = 0; sent < 750; ) begin
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 5);
      case ($urandom_range(0, 3))
        0: fl = 0;
        1: fl = 1023;
        default: fl = $urandom_range(0, 200);
      endcase
      case ($urandom_range(0, 3))
        0: cp = 0;
        1: cp = 256;
        2: cp = 511;
        default: cp = $urandom_range(0, 256);
      endcase
      set_frame(w, h, fl, cp);
      push_frame(w, h, 1);
      sent += w * h + w + 1;
      if (!hold_arm && sent > 200) begin
        @(negedge clk);
        hold_arm = 1'b1;
      end
    end

    wait_idle();
    $display("requests: %0d pixels; results: %0d (%0d blended), %0d frames completed",
             n_pixels, n_results, n_blended, n_frames);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
